### hw/rtl/lcrb_pkg.sv
// Shared types and constants for the LED chain refresh buffer.
`default_nettype none
package lcrb_pkg;

	localparam int LED_COUNT_DEF = 16;
	localparam int IN_IDX_W      = 5;
	localparam int BYTE_W        = 8;

	typedef enum logic [1:0] {
		KIND_SET     = 2'd0,
		KIND_ALL_OFF = 2'd1,
		KIND_REFRESH = 2'd2
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
	} colour_t;

	typedef struct packed {
		logic wr_en;
		logic clr;
		logic rd_en;
	} store_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/lcrb_store.sv
// Colour memory with per-entry valid bits and a registered read port.
`default_nettype none
module lcrb_store #(
	parameter int DEPTH = lcrb_pkg::LED_COUNT_DEF,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  lcrb_pkg::store_ctl_t    ctl,
	input  wire  [IDX_W-1:0]        wr_idx,
	input  lcrb_pkg::colour_t       wr_data,
	input  wire  [IDX_W-1:0]        rd_idx,
	output lcrb_pkg::colour_t       rd_data
);

	lcrb_pkg::colour_t mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	lcrb_pkg::colour_t rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= valid_q[rd_idx] ? mem[rd_idx] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### hw/rtl/led_chain_refresh_buffer.sv
// Top level of the LED chain refresh buffer: item decode, dirty mark and refresh sequencer.
// A set item or an all-off item is taken while the sequencer is idle. A refresh tick with
// entries pending emits three bytes (blue, red, green) for each LED from 0 up to the highest
// changed entry, one byte per cycle while the output is not stalled, and holds the input off
// for the whole run; the single read port of the colour memory fetches the next LED while
// the green byte of the current one leaves. Reset and an all-off item clear the colour memory
// at once and mark the whole chain.
`default_nettype none
module led_chain_refresh_buffer #(
	parameter int LED_COUNT = lcrb_pkg::LED_COUNT_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [1:0]                     kind,
	input  wire  [lcrb_pkg::IN_IDX_W-1:0]  entry_index,
	input  wire  [lcrb_pkg::BYTE_W-1:0]    red_value,
	input  wire  [lcrb_pkg::BYTE_W-1:0]    green_value,
	input  wire  [lcrb_pkg::BYTE_W-1:0]    blue_value,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [lcrb_pkg::BYTE_W-1:0]    chain_byte,
	output logic                           last_of_run
);

	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [lcrb_pkg::IN_IDX_W:0] COUNT_EXT = (lcrb_pkg::IN_IDX_W + 1)'(LED_COUNT);
	localparam logic [IDX_W-1:0] MARK_FULL = IDX_W'(LED_COUNT - 1);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;
	typedef enum logic [1:0] {SUB_BLUE, SUB_RED, SUB_GREEN} sub_t;

	state_t                       state_q;
	sub_t                         sub_q;
	logic [IDX_W-1:0]             pos_q;
	logic [IDX_W-1:0]             run_last_q;
	logic [IDX_W-1:0]             mark_q;
	logic                         flag_q;
	logic                         out_valid_q;
	logic [lcrb_pkg::BYTE_W-1:0]  chain_byte_q;
	logic                         last_of_run_q;

	logic                         in_acc;
	logic                         is_set;
	logic                         is_off;
	logic                         go;
	logic                         slot_free;
	logic                         adv;
	logic                         last_byte;
	logic                         fetch_next;
	logic [IDX_W-1:0]             set_idx;
	logic [IDX_W-1:0]             rd_idx;
	logic [lcrb_pkg::BYTE_W-1:0]  sel_byte;
	lcrb_pkg::store_ctl_t         ctl;
	lcrb_pkg::colour_t            wr_data;
	lcrb_pkg::colour_t            rd_data;

	assign in_stall  = (state_q == ST_RUN);
	assign in_acc    = in_valid && !in_stall;
	assign is_set    = in_acc && (kind == lcrb_pkg::KIND_SET)
			&& ({1'b0, entry_index} < COUNT_EXT);
	assign is_off    = in_acc && (kind == lcrb_pkg::KIND_ALL_OFF);
	assign go        = in_acc && (kind == lcrb_pkg::KIND_REFRESH) && flag_q;
	assign set_idx   = entry_index[IDX_W-1:0];
	assign slot_free = !out_valid_q || !out_stall;
	assign adv       = (state_q == ST_RUN) && slot_free;
	assign last_byte = (sub_q == SUB_GREEN) && (pos_q == run_last_q);
	assign fetch_next = adv && (sub_q == SUB_GREEN) && (pos_q != run_last_q);
	assign rd_idx    = go ? '0 : pos_q + 1'b1;

	assign ctl.wr_en = is_set;
	assign ctl.clr   = is_off;
	assign ctl.rd_en = go || fetch_next;

	assign wr_data.blue  = blue_value;
	assign wr_data.red   = red_value;
	assign wr_data.green = green_value;

	always_comb begin
		case (sub_q)
			SUB_BLUE:  sel_byte = rd_data.blue;
			SUB_RED:   sel_byte = rd_data.red;
			SUB_GREEN: sel_byte = rd_data.green;
			default:   sel_byte = '0;
		endcase
	end

	lcrb_store #(
		.DEPTH (LED_COUNT),
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.wr_idx  (set_idx),
		.wr_data (wr_data),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sub_q         <= SUB_BLUE;
			pos_q         <= '0;
			run_last_q    <= '0;
			mark_q        <= MARK_FULL;
			flag_q        <= 1'b1;
			out_valid_q   <= 1'b0;
			chain_byte_q  <= '0;
			last_of_run_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q   <= 1'b1;
				chain_byte_q  <= sel_byte;
				last_of_run_q <= last_byte;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (is_set) begin
						flag_q <= 1'b1;
						if (!flag_q || (set_idx > mark_q)) begin
							mark_q <= set_idx;
						end
					end
					if (is_off) begin
						flag_q <= 1'b1;
						mark_q <= MARK_FULL;
					end
					if (go) begin
						state_q    <= ST_RUN;
						pos_q      <= '0;
						sub_q      <= SUB_BLUE;
						run_last_q <= mark_q;
						flag_q     <= 1'b0;
						mark_q     <= '0;
					end
				end
				ST_RUN: begin
					if (adv) begin
						case (sub_q)
							SUB_BLUE:  sub_q <= SUB_RED;
							SUB_RED:   sub_q <= SUB_GREEN;
							default: begin
								sub_q <= SUB_BLUE;
								if (pos_q == run_last_q) begin
									state_q <= ST_IDLE;
								end else begin
									pos_q <= pos_q + 1'b1;
								end
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign chain_byte  = chain_byte_q;
	assign last_of_run = last_of_run_q;

	a_no_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (!ctl.wr_en && !ctl.clr))
		else $error("store written during a refresh run");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_byte) |=> (state_q == ST_IDLE) && out_valid_q && last_of_run_q)
		else $error("refresh run did not end on its last byte");

	a_go_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> (state_q == ST_RUN) && !flag_q && (mark_q == '0) && (pos_q == '0))
		else $error("refresh start did not clear pending state");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (pos_q <= run_last_q))
		else $error("refresh position passed the mark");

endmodule
`default_nettype wire
